/* rtl/bmp_grayscale_stream_defines.svh */
// Assertion macros for the grayscale stream block.
`ifndef BMP_GRAYSCALE_STREAM_DEFINES_SVH
`define BMP_GRAYSCALE_STREAM_DEFINES_SVH

// Same-cycle implication, checked on the block clock outside reset.
`define BGS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the block clock outside reset.
`define BGS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/bgs_pkg.sv */
package bgs_pkg;

	localparam logic [31:0] HDR_MIN_END   = 32'd26;
	localparam logic [31:0] OFS_PIX_FIRST = 32'd10;
	localparam logic [31:0] OFS_PIX_LAST  = 32'd13;
	localparam logic [31:0] OFS_WID_FIRST = 32'd18;
	localparam logic [31:0] OFS_WID_LAST  = 32'd21;
	localparam logic [31:0] OFS_HGT_FIRST = 32'd22;
	localparam logic [31:0] OFS_HGT_LAST  = 32'd25;
	localparam logic [1:0]  LANE_BIAS     = 2'd2;

	// 0.21 / 0.72 / 0.07 in 8-bit fixed point, summing to 256
	localparam logic [15:0] W_RED   = 16'd54;
	localparam logic [15:0] W_GREEN = 16'd184;
	localparam logic [15:0] W_BLUE  = 16'd18;

	localparam logic [1:0] BIP_BLUE  = 2'd0;
	localparam logic [1:0] BIP_GREEN = 2'd1;
	localparam logic [1:0] BIP_RED   = 2'd2;

	localparam logic KIND_COPY = 1'b0;
	localparam logic KIND_GRAY = 1'b1;

	localparam logic [1:0] RUN_COPY = 2'd1;
	localparam logic [1:0] RUN_GRAY = 2'd3;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [7:0] green;
		logic [7:0] blue;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [31:0] put_le_byte(input logic [31:0] word,
		input logic [1:0] lane, input logic [7:0] b);
		logic [31:0] res;
		res = word;
		case (lane)
			2'd0: res[7:0]   = b;
			2'd1: res[15:8]  = b;
			2'd2: res[23:16] = b;
			2'd3: res[31:24] = b;
			default: res = word;
		endcase
		return res;
	endfunction

endpackage

/* rtl/bgs_in_if.sv */
interface bgs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       file_start;

	modport source (output valid, output data_byte, output file_start, input ready);
	modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

/* rtl/bgs_out_if.sv */
interface bgs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

/* rtl/bgs_front.sv */
module bgs_front
	import bgs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	bgs_in_if.sink  src,
	input  q_stat_t q_stat,
	output logic    push,
	output cmd_t    push_cmd
);

	logic [31:0] off_q, pdo_q, width_q, height_q, col_q, row_q;
	logic [1:0]  bip_q, pad_q;
	logic [7:0]  blue_q, green_q;

	logic [31:0] e_off, e_pdo, e_width, e_height, e_col, e_row;
	logic [1:0]  e_bip, e_pad;
	logic [31:0] n_off, n_pdo, n_width, n_height, n_col, n_row;
	logic [1:0]  n_bip, n_pad;
	logic [7:0]  n_blue, n_green;
	logic [31:0] col_inc;
	logic [1:0]  lane;
	logic [7:0]  b;
	logic        accept;

	assign src.ready = !q_stat.full;
	assign accept    = src.valid && src.ready;
	assign b         = src.data_byte;

	assign e_off    = src.file_start ? '0 : off_q;
	assign e_pdo    = src.file_start ? '0 : pdo_q;
	assign e_width  = src.file_start ? '0 : width_q;
	assign e_height = src.file_start ? '0 : height_q;
	assign e_col    = src.file_start ? '0 : col_q;
	assign e_row    = src.file_start ? '0 : row_q;
	assign e_bip    = src.file_start ? BIP_BLUE : bip_q;
	assign e_pad    = src.file_start ? 2'd0 : pad_q;

	assign lane    = e_off[1:0] - LANE_BIAS;
	assign col_inc = e_col + 32'd1;

	always_comb begin
		n_off    = (e_off == '1) ? e_off : e_off + 32'd1;
		n_pdo    = e_pdo;
		n_width  = e_width;
		n_height = e_height;
		n_col    = e_col;
		n_row    = e_row;
		n_bip    = e_bip;
		n_pad    = e_pad;
		n_blue   = src.file_start ? 8'd0 : blue_q;
		n_green  = src.file_start ? 8'd0 : green_q;
		push     = 1'b0;
		push_cmd = '{kind: KIND_COPY, data: b, green: n_green, blue: n_blue};
		if (e_off < HDR_MIN_END || e_off < e_pdo) begin
			if (e_off >= OFS_PIX_FIRST && e_off <= OFS_PIX_LAST) begin
				n_pdo = put_le_byte(e_pdo, lane, b);
			end else if (e_off >= OFS_WID_FIRST && e_off <= OFS_WID_LAST) begin
				n_width = put_le_byte(e_width, lane, b);
			end else if (e_off >= OFS_HGT_FIRST && e_off <= OFS_HGT_LAST) begin
				n_height = put_le_byte(e_height, lane, b);
			end
			push = 1'b1;
		end else if (e_width == '0 || e_row >= e_height) begin
			push = 1'b0;
		end else if (e_pad != 2'd0) begin
			n_pad = e_pad - 2'd1;
			if (n_pad == 2'd0) begin
				n_row = e_row + 32'd1;
			end
			push = 1'b1;
		end else if (e_bip == BIP_BLUE) begin
			n_blue = b;
			n_bip  = BIP_GREEN;
		end else if (e_bip == BIP_GREEN) begin
			n_green = b;
			n_bip   = BIP_RED;
		end else begin
			n_bip         = BIP_BLUE;
			push          = 1'b1;
			push_cmd.kind = KIND_GRAY;
			if (col_inc >= e_width) begin
				n_col = '0;
				// row padding (4 - 3w mod 4) mod 4 reduces to w mod 4
				if (e_width[1:0] == 2'd0) begin
					n_row = e_row + 32'd1;
				end else begin
					n_pad = e_width[1:0];
				end
			end else begin
				n_col = col_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q    <= '0;
			pdo_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
			bip_q    <= BIP_BLUE;
			pad_q    <= 2'd0;
			blue_q   <= '0;
			green_q  <= '0;
		end else if (accept) begin
			off_q    <= n_off;
			pdo_q    <= n_pdo;
			width_q  <= n_width;
			height_q <= n_height;
			col_q    <= n_col;
			row_q    <= n_row;
			bip_q    <= n_bip;
			pad_q    <= n_pad;
			blue_q   <= n_blue;
			green_q  <= n_green;
		end
	end

endmodule

/* rtl/bgs_queue.sv */
module bgs_queue
	import bgs_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    head,
	output q_stat_t q_stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign q_stat.full  = (cnt_q == CW'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign head         = mem_q[rd_ptr_q];
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/bgs_back.sv */
module bgs_back
	import bgs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cmd_t     head,
	input  q_stat_t  q_stat,
	output logic     pop,
	bgs_out_if.source dst
);

	logic [1:0]  cnt_q;
	logic [7:0]  val_q;
	logic [15:0] weighted;
	logic [7:0]  gray;

	assign weighted = {8'd0, head.data} * W_RED + {8'd0, head.green} * W_GREEN
		+ {8'd0, head.blue} * W_BLUE;
	assign gray     = weighted[15:8];

	assign dst.valid       = (cnt_q != 2'd0);
	assign dst.out_byte    = val_q;
	assign dst.last_of_run = (cnt_q == 2'd1);

	assign pop = !q_stat.empty && (cnt_q == 2'd0 || (cnt_q == 2'd1 && dst.ready));

	always_ff @(posedge clk) begin
		if (pop) begin
			val_q <= (head.kind == KIND_GRAY) ? gray : head.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (pop) begin
			cnt_q <= (head.kind == KIND_GRAY) ? RUN_GRAY : RUN_COPY;
		end else if (dst.valid && dst.ready) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

/* rtl/bmp_grayscale_stream.sv */
// Path: a copied byte is written into the command queue, then loaded into the output
// register and offered at dst; a red byte starts its three gray bytes by the same path.
// Throughput: one src transaction per cycle while the command queue has room; each
// red byte holds the output register for its three gray bytes, blue and green bytes none.
// Reset (arst_n low): all header, position and pixel state clears, queue empties.
`include "bmp_grayscale_stream_defines.svh"

module bmp_grayscale_stream
	import bgs_pkg::*;
#(
	parameter int QDEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	bgs_in_if.sink    src,
	bgs_out_if.source dst
);

	q_stat_t q_stat;
	cmd_t    push_cmd;
	cmd_t    head;
	logic    push;
	logic    pop;

	bgs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.src      (src),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	bgs_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push && src.valid && src.ready),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	bgs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.dst    (dst)
	);

	`BGS_ASSERT_NEXT(a_gray_run_holds, dst.valid && dst.ready && !dst.last_of_run, dst.valid && $stable(dst.out_byte), "gray run broken")
	`BGS_ASSERT_NEXT(a_push_lands, push && src.valid && src.ready, !q_stat.empty || dst.valid, "queued transaction lost")
	`BGS_ASSERT_SAME(a_stall_full, !src.ready, q_stat.full, "input stalled without full queue")

endmodule
